// ----- rtl/pvec_pkg.sv -----
// Package for the permuted volume element converter.
// Register indexes, reset values, fixed field widths and the setup state type.
// No dependencies.
`default_nettype none

package pvec_pkg;

    // Fixed field widths
    localparam int RAW_W         = 64;
    localparam int VALUE_W       = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int SIZES_W       = 56;
    localparam int ORDER_W       = 21;
    localparam int ORDER_FIELD_W = 3;
    localparam int SCALE_W       = 32;
    localparam int OFFSET_W      = 32;
    localparam int FRAC_BITS     = 16;

    // Register reset values
    localparam logic [SIZES_W-1:0]  SIZES_RESET  = '0;
    localparam logic [ORDER_W-1:0]  ORDER_RESET  = 21'd1754760;
    localparam logic [SCALE_W-1:0]  SCALE_ONE    = 32'h0001_0000;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS_SIZES  = 3'd0,
        CFG_AXIS_ORDER  = 3'd1,
        CFG_ELEM_BYTES  = 3'd2,
        CFG_ELEM_SIGNED = 3'd3,
        CFG_SWAP_EN     = 3'd4,
        CFG_SCALE       = 3'd5,
        CFG_OFFSET      = 3'd6
    } cfg_index_t;

    // Element width codes
    typedef enum logic [1:0] {
        ELEM_1B = 2'd0,
        ELEM_2B = 2'd1,
        ELEM_4B = 2'd2,
        ELEM_8B = 2'd3
    } elem_size_t;

    // Stride setup sequencer
    typedef enum logic [1:0] {
        SEQ_INIT,
        SEQ_STRIDE,
        SEQ_DELTA,
        SEQ_DONE
    } seq_state_t;

endpackage

`default_nettype wire

// ----- rtl/pvec_ifs.sv -----
// Stream and configuration channel interfaces of the converter.
// Depends on pvec_pkg for the field widths.
`default_nettype none

interface pvec_elem_if
    import pvec_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_element;

    modport source (output valid, output raw_element, input ready);
    modport sink   (input valid, input raw_element, output ready);
endinterface

interface pvec_result_if
    import pvec_pkg::*;
#(
    parameter int ADDR_BITS = 32
) ();
    logic                       valid;
    logic                       ready;
    logic [ADDR_BITS-1:0]       out_address;
    logic signed [VALUE_W-1:0]  out_value;
    logic                       saturated;
    logic                       last_element;

    modport source (output valid, output out_address, output out_value,
                    output saturated, output last_element, input ready);
    modport sink   (input valid, input out_address, input out_value,
                    input saturated, input last_element, output ready);
endinterface

interface pvec_cfg_if
    import pvec_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pvec_stride_gen.sv -----
// Stride and address-step setup for the converter.
// Builds per-axis strides from the axis order, then the address step taken
// when each axis advances. Depends on pvec_pkg.
`default_nettype none

module pvec_stride_gen
    import pvec_pkg::*;
#(
    parameter int NUM_AXES  = 7,
    parameter int AXIS_BITS = 8,
    parameter int ADDR_BITS = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   restart,
    input  wire logic [NUM_AXES-1:0][AXIS_BITS-1:0]     limits,
    input  wire logic [ORDER_W-1:0]                     axis_order,
    output logic                                        busy,
    output logic      [NUM_AXES-1:0][ADDR_BITS-1:0]     deltas
);

    localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int CNT_W = $clog2(NUM_AXES + 1);
    localparam logic [CNT_W-1:0] LAST_AXIS = CNT_W'(NUM_AXES - 1);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    seq_state_t state_reg, state_next;
    logic [CNT_W-1:0] i_reg, j_reg, k_reg;
    logic [ADDR_BITS-1:0] acc_reg;
    logic [NUM_AXES-1:0][ADDR_BITS-1:0] stride_reg;
    logic [NUM_AXES-1:0][ADDR_BITS-1:0] delta_reg;

    logic [ORDER_FIELD_W-1:0] tgt, src;
    logic tgt_ok, src_ok, row_end;
    logic [IDX_W-1:0] sel_idx;
    logic [AXIS_BITS:0] mul_fac;
    logic [ADDR_BITS+AXIS_BITS:0] mul_full;
    logic [ADDR_BITS-1:0] product;
    logic stride_init, stride_we, delta_we;

    // Order fields for the current position pair
    always_comb
    begin
        tgt     = axis_order[ORDER_FIELD_W*i_reg +: ORDER_FIELD_W];
        src     = axis_order[ORDER_FIELD_W*j_reg +: ORDER_FIELD_W];
        tgt_ok  = int'(tgt) < NUM_AXES;
        src_ok  = int'(src) < NUM_AXES;
        row_end = (j_reg == i_reg - CNT_ONE);
    end

    // Shared multiplier: stride times size, or stride times axis limit
    always_comb
    begin
        if (state_reg == SEQ_DELTA)
        begin
            sel_idx = k_reg[IDX_W-1:0];
            mul_fac = {1'b0, limits[k_reg[IDX_W-1:0]]};
        end
        else
        begin
            sel_idx = tgt[IDX_W-1:0];
            mul_fac = src_ok ? ({1'b0, limits[src[IDX_W-1:0]]} + 1'b1)
                             : (AXIS_BITS+1)'(1);
        end
        mul_full = stride_reg[sel_idx] * mul_fac;
        product  = mul_full[ADDR_BITS-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_INIT:   state_next = (NUM_AXES > 1) ? SEQ_STRIDE : SEQ_DELTA;
            SEQ_STRIDE: if (row_end && i_reg == LAST_AXIS) state_next = SEQ_DELTA;
            SEQ_DELTA:  if (k_reg == LAST_AXIS) state_next = SEQ_DONE;
            SEQ_DONE:   state_next = SEQ_DONE;
            default:    state_next = SEQ_INIT;
        endcase
        if (restart)
            state_next = SEQ_INIT;
    end

    // Outputs of the sequencer
    always_comb
    begin
        busy        = 1'b1;
        stride_init = 1'b0;
        stride_we   = 1'b0;
        delta_we    = 1'b0;
        case (state_reg)
            SEQ_INIT:   stride_init = 1'b1;
            SEQ_STRIDE: stride_we   = tgt_ok;
            SEQ_DELTA:  delta_we    = 1'b1;
            SEQ_DONE:   busy        = 1'b0;
            default:    busy        = 1'b1;
        endcase
    end

    // State and step counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_INIT;
            i_reg     <= CNT_ONE;
            j_reg     <= '0;
            k_reg     <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (restart || stride_init)
            begin
                i_reg   <= CNT_ONE;
                j_reg   <= '0;
                k_reg   <= '0;
                acc_reg <= '0;
            end
            else if (state_reg == SEQ_STRIDE)
            begin
                if (row_end)
                begin
                    i_reg <= i_reg + CNT_ONE;
                    j_reg <= '0;
                end
                else
                    j_reg <= j_reg + CNT_ONE;
            end
            else if (delta_we)
            begin
                k_reg   <= k_reg + CNT_ONE;
                acc_reg <= acc_reg + product;
            end
        end
    end

    // Stride and step storage
    always_ff @(posedge clk)
    begin
        if (stride_init)
        begin
            for (int a = 0; a < NUM_AXES; a++)
                stride_reg[a] <= ADDR_BITS'(1);
        end
        else if (stride_we)
            stride_reg[sel_idx] <= product;
        // step when axis k advances: its stride minus the span of the lower axes
        if (delta_we)
            delta_reg[sel_idx] <= stride_reg[sel_idx] - acc_reg;
    end

    assign deltas = delta_reg;

endmodule

`default_nettype wire

// ----- rtl/permuted_volume_element_converter.sv -----
// Top level of the permuted volume element converter.
// Uses pvec_pkg, the channel interfaces in pvec_ifs and pvec_stride_gen.
`default_nettype none

// Takes one raw element per beat, axis 0 fastest, and returns one result per
// element: its address in the permuted volume, the value after byte swap,
// extension, Q16.16 scale and offset with 64-bit saturation, and a mark on the
// last element of the volume. The block accepts one element per cycle when
// neither the result channel nor a setup pass holds it off; each element runs
// through a five-stage pipeline (input, extend, two 32x32 partial products,
// offset add, round and clip). The address follows an incremental counter that
// adds a precomputed step per element. After reset and after every write to one
// of the seven registers the strides and steps are rebuilt by one shared
// multiplier; no element is accepted during that pass. Such a write also
// starts a new volume.
module permuted_volume_element_converter
    import pvec_pkg::*;
#(
    parameter int NUM_AXES  = 7,
    parameter int AXIS_BITS = 8,
    parameter int ADDR_BITS = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    pvec_elem_if.sink      elements,
    pvec_result_if.source  results,
    pvec_cfg_if.sink       config_wr
);

    localparam int NSTAGE   = 5;
    localparam int SZ_EXT_W = SIZES_W + NUM_AXES*AXIS_BITS;
    localparam int PROD_W   = 96;
    localparam int SUM_W    = 98;
    localparam int Q_W      = SUM_W - FRAC_BITS;

    // Configuration registers
    logic [SIZES_W-1:0]  sizes_reg;
    logic [ORDER_W-1:0]  order_reg;
    elem_size_t          bytes_log2_reg;
    logic                signed_reg;
    logic                swap_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                cfg_hit;

    // Counters and address
    logic [NUM_AXES-1:0][AXIS_BITS-1:0] limits;
    logic [NUM_AXES-1:0][AXIS_BITS-1:0] pos_reg, pos_next;
    logic [NUM_AXES-1:0][ADDR_BITS-1:0] deltas;
    logic [ADDR_BITS-1:0] cur_addr_reg, cur_addr_next;
    logic [SZ_EXT_W-1:0]  sizes_ext;
    logic                 found;
    logic                 seq_busy;
    logic                 accept;

    // Pipeline control and tags
    logic [NSTAGE-1:0]    vld_reg;
    logic [NSTAGE-1:0]    adv;
    logic [ADDR_BITS-1:0] addr_pipe [NSTAGE];
    logic                 last_pipe [NSTAGE];

    // Value pipeline
    logic [RAW_W-1:0]    s1_raw;
    logic [RAW_W-1:0]    sw, lowmask;
    logic                msb, fill;
    logic [RAW_W:0]      ext_c, neg_c;
    logic [RAW_W:0]      s2_v;
    logic [RAW_W-1:0]    s2_mag;
    logic                s2_neg;
    logic                identity, sneg;
    logic [SCALE_W-1:0]  smag;
    logic [63:0]         p0_c, p1_c;
    logic [63:0]         s3_p0, s3_p1;
    logic                s3_neg;
    logic [RAW_W:0]      s3_v;
    logic [PROD_W-1:0]   prod_c;
    logic [SUM_W-1:0]    prod_s, sum_c;
    logic [SUM_W-1:0]    s4_sum;
    logic [RAW_W:0]      s4_v;
    logic [SUM_W-1:0]    rnd_c;
    logic [Q_W-1:0]      fin_c;
    logic                ovf_hi, ovf_lo;
    logic [VALUE_W-1:0]  val_c;
    logic [VALUE_W-1:0]  out_value_reg;
    logic                sat_reg;

    // Configuration writes
    assign config_wr.ready = 1'b1;

    always_comb
    begin
        case (config_wr.index)
            CFG_AXIS_SIZES, CFG_AXIS_ORDER, CFG_ELEM_BYTES, CFG_ELEM_SIGNED,
            CFG_SWAP_EN, CFG_SCALE, CFG_OFFSET: cfg_hit = config_wr.valid;
            default:                            cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sizes_reg      <= SIZES_RESET;
            order_reg      <= ORDER_RESET;
            bytes_log2_reg <= ELEM_1B;
            signed_reg     <= 1'b0;
            swap_reg       <= 1'b0;
            scale_reg      <= SCALE_ONE;
            offset_reg     <= OFFSET_RESET;
        end
        else if (config_wr.valid)
        begin
            case (config_wr.index)
                CFG_AXIS_SIZES:  sizes_reg      <= config_wr.data[SIZES_W-1:0];
                CFG_AXIS_ORDER:  order_reg      <= config_wr.data[ORDER_W-1:0];
                CFG_ELEM_BYTES:  bytes_log2_reg <= elem_size_t'(config_wr.data[1:0]);
                CFG_ELEM_SIGNED: signed_reg     <= config_wr.data[0];
                CFG_SWAP_EN:     swap_reg       <= config_wr.data[0];
                CFG_SCALE:       scale_reg      <= config_wr.data[SCALE_W-1:0];
                CFG_OFFSET:      offset_reg     <= config_wr.data[OFFSET_W-1:0];
                default:         sizes_reg      <= sizes_reg;
            endcase
        end
    end

    // Axis limits; fields past the size register read as zero
    assign sizes_ext = {{(NUM_AXES*AXIS_BITS){1'b0}}, sizes_reg};

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
            limits[k] = sizes_ext[k*AXIS_BITS +: AXIS_BITS];
    end

    pvec_stride_gen #(
        .NUM_AXES  (NUM_AXES),
        .AXIS_BITS (AXIS_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_stride_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_hit),
        .limits     (limits),
        .axis_order (order_reg),
        .busy       (seq_busy),
        .deltas     (deltas)
    );

    // Handshakes and pipeline advance
    always_comb
    begin
        adv[NSTAGE-1] = !vld_reg[NSTAGE-1] || results.ready;
        for (int s = NSTAGE-2; s >= 0; s--)
            adv[s] = !vld_reg[s] || adv[s+1];
    end

    assign elements.ready = adv[0] && !seq_busy;
    assign accept         = elements.valid && elements.ready;

    // Position counters: lowest axis not at its limit advances, lower ones wrap
    always_comb
    begin
        pos_next      = pos_reg;
        found         = 1'b0;
        cur_addr_next = '0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            if (!found)
            begin
                if (pos_reg[k] == limits[k])
                    pos_next[k] = '0;
                else
                begin
                    pos_next[k]   = pos_reg[k] + 1'b1;
                    cur_addr_next = cur_addr_reg + deltas[k];
                    found         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            cur_addr_reg <= '0;
        end
        else if (cfg_hit)
        begin
            pos_reg      <= '0;
            cur_addr_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            cur_addr_reg <= cur_addr_next;
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= accept;
            for (int s = 1; s < NSTAGE; s++)
                if (adv[s])
                    vld_reg[s] <= vld_reg[s-1];
        end
    end

    // Address and last mark travel with the value
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            addr_pipe[0] <= cur_addr_reg;
            last_pipe[0] <= !found;
        end
        for (int s = 1; s < NSTAGE; s++)
            if (adv[s])
            begin
                addr_pipe[s] <= addr_pipe[s-1];
                last_pipe[s] <= last_pipe[s-1];
            end
    end

    // Extend stage: mask to width, optional byte reversal, sign or zero fill
    always_comb
    begin
        sw      = '0;
        lowmask = '0;
        msb     = 1'b0;
        case (bytes_log2_reg)
            ELEM_1B:
            begin
                sw[7:0]      = s1_raw[7:0];
                lowmask[7:0] = '1;
                msb          = sw[7];
            end
            ELEM_2B:
            begin
                for (int b = 0; b < 2; b++)
                    sw[8*b +: 8] = swap_reg ? s1_raw[8*(1-b) +: 8] : s1_raw[8*b +: 8];
                lowmask[15:0] = '1;
                msb           = sw[15];
            end
            ELEM_4B:
            begin
                for (int b = 0; b < 4; b++)
                    sw[8*b +: 8] = swap_reg ? s1_raw[8*(3-b) +: 8] : s1_raw[8*b +: 8];
                lowmask[31:0] = '1;
                msb           = sw[31];
            end
            default:
            begin
                for (int b = 0; b < 8; b++)
                    sw[8*b +: 8] = swap_reg ? s1_raw[8*(7-b) +: 8] : s1_raw[8*b +: 8];
                lowmask = '1;
                msb     = sw[63];
            end
        endcase
        fill  = signed_reg && msb;
        ext_c = {fill, sw | (fill ? ~lowmask : '0)};
        neg_c = ~ext_c + 1'b1;
    end

    // Scale magnitude, the cases that skip scaling and the two partial products
    always_comb
    begin
        sneg     = scale_reg[SCALE_W-1];
        smag     = sneg ? (~scale_reg + 1'b1) : scale_reg;
        identity = (scale_reg == '0) || (scale_reg == SCALE_ONE && offset_reg == '0);
        p0_c     = s2_mag[31:0]  * smag;
        p1_c     = s2_mag[63:32] * smag;
    end

    // Signed product plus offset in Q16.16
    always_comb
    begin
        prod_c = {32'b0, s3_p0} + {s3_p1, 32'b0};
        prod_s = s3_neg ? (~{2'b00, prod_c} + 1'b1) : {2'b00, prod_c};
        sum_c  = prod_s + {{50{offset_reg[OFFSET_W-1]}}, offset_reg, 16'b0};
    end

    // Truncate toward zero, pick the unscaled value, clip to 64 bits
    always_comb
    begin
        rnd_c  = s4_sum + (s4_sum[SUM_W-1] ? SUM_W'(16'hFFFF) : '0);
        fin_c  = identity ? {{(Q_W-RAW_W-1){s4_v[RAW_W]}}, s4_v} : rnd_c[SUM_W-1:FRAC_BITS];
        ovf_hi = !fin_c[Q_W-1] && (|fin_c[Q_W-2:VALUE_W-1]);
        ovf_lo =  fin_c[Q_W-1] && !(&fin_c[Q_W-2:VALUE_W-1]);
        if (ovf_hi)
            val_c = {1'b0, {(VALUE_W-1){1'b1}}};
        else if (ovf_lo)
            val_c = {1'b1, {(VALUE_W-1){1'b0}}};
        else
            val_c = fin_c[VALUE_W-1:0];
    end

    // Value pipeline registers
    always_ff @(posedge clk)
    begin
        if (adv[0])
            s1_raw <= elements.raw_element;
        if (adv[1])
        begin
            s2_v   <= ext_c;
            s2_mag <= ext_c[RAW_W] ? neg_c[RAW_W-1:0] : ext_c[RAW_W-1:0];
            s2_neg <= ext_c[RAW_W];
        end
        if (adv[2])
        begin
            s3_p0  <= p0_c;
            s3_p1  <= p1_c;
            s3_neg <= s2_neg ^ sneg;
            s3_v   <= s2_v;
        end
        if (adv[3])
        begin
            s4_sum <= sum_c;
            s4_v   <= s3_v;
        end
        if (adv[4])
        begin
            out_value_reg <= val_c;
            sat_reg       <= ovf_hi || ovf_lo;
        end
    end

    // Result channel
    assign results.valid        = vld_reg[NSTAGE-1];
    assign results.out_address  = addr_pipe[NSTAGE-1];
    assign results.out_value    = out_value_reg;
    assign results.saturated    = sat_reg;
    assign results.last_element = last_pipe[NSTAGE-1];

endmodule

`default_nettype wire

// ----- bench/tb_permuted_volume_element_converter.sv -----
// Self-checking bench for the permuted volume element converter: a directed table,
// then randomized setups and element streams, scored against table values or an in-bench predictor.
// Depends on pvec_pkg, the channel interfaces in pvec_ifs and the converter RTL.
`default_nettype none

module tb_permuted_volume_element_converter
    import pvec_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AXES        = 7;
    localparam int PHASES      = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;
    localparam int MAX_REPORTS = 100;
    localparam int NUM_ROWS    = 44;

    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] SAT_LO = -SAT_HI - 128'sd1;
    localparam logic signed [127:0] Q_ONE  = 128'sd65536;

    typedef struct packed {
        logic [31:0] addr;
        logic [63:0] value;
        logic        sat;
        logic        last;
    } result_t;

    typedef struct packed {
        logic       is_reg;
        cfg_index_t idx;
        logic [63:0] data;
        logic       typed;
        result_t    want;
    } row_t;

    logic clk;
    logic rst_n;

    pvec_elem_if                     elem_ch ();
    pvec_result_if #(.ADDR_BITS(32)) res_ch ();
    pvec_cfg_if                      cfg_ch ();

    permuted_volume_element_converter #(
        .NUM_AXES  (AXES),
        .AXIS_BITS (8),
        .ADDR_BITS (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .elements  (elem_ch),
        .results   (res_ch),
        .config_wr (cfg_ch)
    );

    // Predictor copy of the registers and the volume counters
    logic [55:0]        sizes_cfg;
    logic [20:0]        order_cfg;
    elem_size_t         bytes_cfg;
    logic               signed_cfg;
    logic               swap_cfg;
    logic signed [31:0] scale_cfg;
    logic signed [31:0] offset_cfg;
    logic [7:0]         axis_pos [AXES];
    logic [31:0]        stride_tab [AXES];

    result_t expected_results [$];

    bit gaps_on;
    int errors;
    int items_sent;
    int regs_written;
    int results_seen;
    int sat_seen;
    int ends_seen;

    // Directed table: typed expectations only where they are obvious
    row_t directed_rows [NUM_ROWS] = '{
        // single-element volume, 1-byte unsigned, identity mapping
        '{1'b0, CFG_AXIS_SIZES, 64'h0, 1'b1, '{32'd0, 64'd0, 1'b0, 1'b1}},
        '{1'b0, CFG_AXIS_SIZES, ONES, 1'b1, '{32'd0, 64'd255, 1'b0, 1'b1}},
        // 8-byte unsigned: top half clips
        '{1'b1, CFG_ELEM_BYTES, 64'(ELEM_8B), 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, ONES, 1'b1, '{32'd0, MAX64, 1'b1, 1'b1}},
        '{1'b0, CFG_AXIS_SIZES, MIN64, 1'b1, '{32'd0, MAX64, 1'b1, 1'b1}},
        // 8-byte signed
        '{1'b1, CFG_ELEM_SIGNED, 64'd1, 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, ONES, 1'b1, '{32'd0, ONES, 1'b0, 1'b1}},
        '{1'b0, CFG_AXIS_SIZES, MIN64, 1'b1, '{32'd0, MIN64, 1'b0, 1'b1}},
        // byte swap at 8, 2 and 4 bytes
        '{1'b1, CFG_SWAP_EN, 64'd1, 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'h0102_0304_0506_0708, 1'b1,
          '{32'd0, 64'h0807_0605_0403_0201, 1'b0, 1'b1}},
        '{1'b1, CFG_ELEM_BYTES, 64'(ELEM_2B), 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'h1234_5678_9ABC_00FF, 1'b1,
          '{32'd0, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b1}},
        '{1'b1, CFG_ELEM_BYTES, 64'(ELEM_4B), 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'h0000_0000_0000_0080, 1'b1,
          '{32'd0, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b1}},
        '{1'b1, CFG_SWAP_EN, 64'd0, 1'b0, '0},
        '{1'b1, CFG_ELEM_BYTES, 64'(ELEM_8B), 1'b0, '0},
        // scale 2.0 clips both ways
        '{1'b1, CFG_SCALE, 64'h0002_0000, 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'h4000_0000_0000_0000, 1'b1, '{32'd0, MAX64, 1'b1, 1'b1}},
        '{1'b0, CFG_AXIS_SIZES, 64'hBFFF_FFFF_FFFF_FFFF, 1'b1, '{32'd0, MIN64, 1'b1, 1'b1}},
        // most negative scale
        '{1'b1, CFG_SCALE, 64'h8000_0000, 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'd3, 1'b1, '{32'd0, 64'hFFFF_FFFF_FFFE_8000, 1'b0, 1'b1}},
        '{1'b0, CFG_AXIS_SIZES, MIN64, 1'b1, '{32'd0, MAX64, 1'b1, 1'b1}},
        // most positive scale, truncation of a negative product
        '{1'b1, CFG_SCALE, 64'h7FFF_FFFF, 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, MAX64, 1'b1, '{32'd0, MAX64, 1'b1, 1'b1}},
        '{1'b0, CFG_AXIS_SIZES, 64'hFFFF_FFFF_FFFF_FFFB, 1'b0, '0},
        // zero scale bypasses even with an offset
        '{1'b1, CFG_SCALE, 64'd0, 1'b0, '0},
        '{1'b1, CFG_OFFSET, 64'h7FFF_FFFF, 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'h1234, 1'b1, '{32'd0, 64'h1234, 1'b0, 1'b1}},
        // unit scale with offset extremes
        '{1'b1, CFG_SCALE, 64'(SCALE_ONE), 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'h7FFF_FFFF_0000_0000, 1'b1,
          '{32'd0, 64'h7FFF_FFFF_7FFF_FFFF, 1'b0, 1'b1}},
        '{1'b1, CFG_OFFSET, 64'h8000_0000, 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'd0, 1'b1, '{32'd0, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b1}},
        '{1'b0, CFG_AXIS_SIZES, MIN64, 1'b1, '{32'd0, MIN64, 1'b1, 1'b1}},
        '{1'b1, CFG_OFFSET, 64'd0, 1'b0, '0},
        // 1-byte signed ignores the upper bits
        '{1'b1, CFG_ELEM_BYTES, 64'(ELEM_1B), 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'h5A5A_5A5A_5A5A_5A80, 1'b1,
          '{32'd0, 64'hFFFF_FFFF_FFFF_FF80, 1'b0, 1'b1}},
        // 2x3 volume with the first two axes swapped
        '{1'b1, CFG_AXIS_SIZES, 64'h0201, 1'b0, '0},
        '{1'b1, CFG_AXIS_ORDER, 64'd1754753, 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'h11, 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'h22, 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'h33, 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'h44, 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'h55, 1'b0, '0},
        '{1'b0, CFG_AXIS_SIZES, 64'h66, 1'b0, '0}
    };

    // Clear the counters and rebuild the strides from the current order and sizes
    function automatic void restart_volume();
        int tgt;
        int src;
        logic [31:0] sz;
        for (int k = 0; k < AXES; k++)
        begin
            axis_pos[k]   = '0;
            stride_tab[k] = 32'd1;
        end
        for (int i = 1; i < AXES; i++)
        begin
            tgt = int'(order_cfg[3*i +: 3]);
            if (tgt < AXES)
            begin
                for (int j = 0; j < i; j++)
                begin
                    src = int'(order_cfg[3*j +: 3]);
                    sz  = (src < AXES) ? 32'(sizes_cfg[8*src +: 8]) + 32'd1 : 32'd1;
                    stride_tab[tgt] = stride_tab[tgt] * sz;
                end
            end
        end
    endfunction

    function automatic void apply_register(cfg_index_t idx, logic [63:0] d);
        case (idx)
            CFG_AXIS_SIZES:  sizes_cfg  = d[55:0];
            CFG_AXIS_ORDER:  order_cfg  = d[20:0];
            CFG_ELEM_BYTES:  bytes_cfg  = elem_size_t'(d[1:0]);
            CFG_ELEM_SIGNED: signed_cfg = d[0];
            CFG_SWAP_EN:     swap_cfg   = d[0];
            CFG_SCALE:       scale_cfg  = d[31:0];
            CFG_OFFSET:      offset_cfg = d[31:0];
            default: ;
        endcase
        restart_volume();
    endfunction

    // Expected result of one element; advances the volume counters
    function automatic result_t predict_element(logic [63:0] raw);
        result_t res;
        int nbits;
        logic [63:0] mask;
        logic [63:0] r;
        logic [63:0] s;
        logic signed [127:0] v;
        logic signed [127:0] sc;
        logic signed [127:0] of;
        logic signed [127:0] acc;
        logic carry;

        nbits = 8 << int'(bytes_cfg);
        mask  = (nbits == 64) ? ONES : ((64'd1 << nbits) - 64'd1);
        r     = raw & mask;
        if (swap_cfg)
        begin
            s = '0;
            for (int k = 0; k < nbits / 8; k++)
                s[8*(nbits/8 - 1 - k) +: 8] = r[8*k +: 8];
            r = s;
        end
        if (signed_cfg && r[nbits-1])
            v = {ONES, r | ~mask};
        else
            v = {64'd0, r};

        // zero scale, or unit scale without offset, passes the value through
        if (scale_cfg == 32'sd0 || (scale_cfg == 32'sh0001_0000 && offset_cfg == 32'sd0))
            acc = v;
        else
        begin
            sc  = scale_cfg;
            of  = offset_cfg;
            acc = (v * sc + (of <<< 16)) / Q_ONE;
        end

        if (acc > SAT_HI)
        begin
            res.value = MAX64;
            res.sat   = 1'b1;
        end
        else if (acc < SAT_LO)
        begin
            res.value = MIN64;
            res.sat   = 1'b1;
        end
        else
        begin
            res.value = acc[63:0];
            res.sat   = 1'b0;
        end

        res.addr = '0;
        res.last = 1'b1;
        for (int k = 0; k < AXES; k++)
        begin
            res.addr = res.addr + {24'd0, axis_pos[k]} * stride_tab[k];
            if (axis_pos[k] != sizes_cfg[8*k +: 8])
                res.last = 1'b0;
        end

        // odometer step, axis 0 fastest
        carry = 1'b1;
        for (int k = 0; k < AXES; k++)
        begin
            if (carry)
            begin
                if (axis_pos[k] >= sizes_cfg[8*k +: 8])
                    axis_pos[k] = '0;
                else
                begin
                    axis_pos[k] = axis_pos[k] + 8'd1;
                    carry       = 1'b0;
                end
            end
        end
        return res;
    endfunction

    // Drop the element valid and wait for every pending result
    task automatic hold_until_drained();
        elem_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Register beat; only issued with the pipeline empty
    task automatic write_reg(cfg_index_t idx, logic [63:0] d);
        hold_until_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_register(idx, d);
        regs_written++;
    endtask

    // Element beat with an optional idle burst in front
    task automatic send_element(logic [63:0] raw, logic typed, result_t want);
        result_t pred;
        cfg_ch.valid <= 1'b0;
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            elem_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19))
                @(posedge clk);
        end
        elem_ch.valid       <= 1'b1;
        elem_ch.raw_element <= raw;
        do
            @(posedge clk);
        while (!elem_ch.ready);
        pred = predict_element(raw);
        expected_results.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic check_field(string label, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // Result side: random stall bursts
    initial
    begin
        int stall;
        stall = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
                stall--;
            else if (gaps_on && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 19);
            res_ch.ready <= (stall == 0);
        end
    end

    // Scoreboard: each result beat against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (res_ch.saturated)
                sat_seen++;
            if (res_ch.last_element)
                ends_seen++;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected: addr %h value %h",
                         $time, res_ch.out_address, res_ch.out_value);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("out_address", 64'(want.addr), 64'(res_ch.out_address));
                check_field("out_value", want.value, res_ch.out_value);
                check_field("saturated", 64'(want.sat), 64'(res_ch.saturated));
                check_field("last_element", 64'(want.last), 64'(res_ch.last_element));
            end
        end
    end

    // Watchdog on cycles with no beat on any channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, expected_results.size());
        $display("tb_permuted_volume_element_converter: done, errors");
        $finish;
    end

    // Stimulus
    initial
    begin
        int perm [AXES];
        int j;
        int tmp;
        int n_items;
        logic [63:0] rnd;
        logic [63:0] raw;
        logic [55:0] sz;
        logic [20:0] ord;

        rst_n               <= 1'b0;
        elem_ch.valid       <= 1'b0;
        elem_ch.raw_element <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_AXIS_SIZES;
        cfg_ch.data         <= '0;
        gaps_on      = 1'b1;
        errors       = 0;
        items_sent   = 0;
        regs_written = 0;
        results_seen = 0;
        sat_seen     = 0;
        ends_seen    = 0;

        // predictor in its reset state
        sizes_cfg  = SIZES_RESET;
        order_cfg  = ORDER_RESET;
        bytes_cfg  = ELEM_1B;
        signed_cfg = 1'b0;
        swap_cfg   = 1'b0;
        scale_cfg  = SCALE_ONE;
        offset_cfg = OFFSET_RESET;
        restart_volume();

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (directed_rows[r].is_reg)
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            else
                send_element(directed_rows[r].data, directed_rows[r].typed,
                             directed_rows[r].want);
        end

        // random setups, each followed by an element stream
        for (int phase = 0; phase < PHASES; phase++)
        begin
            gaps_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);

            if (phase == 0 || $urandom_range(0, 1) == 0)
            begin
                rnd = {$urandom, $urandom};
                case ($urandom_range(0, 7))
                    0: sz = '1;
                    1: sz = rnd[55:0];
                    2: sz = '0;
                    default:
                    begin
                        for (int k = 0; k < AXES; k++)
                            sz[8*k +: 8] = ($urandom_range(0, 2) == 0) ?
                                           8'($urandom_range(0, 3)) : 8'd0;
                    end
                endcase
                write_reg(CFG_AXIS_SIZES, {8'd0, sz});
            end

            if (phase == 0 || $urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: ord = 21'($urandom);
                    1: ord = ORDER_RESET;
                    default:
                    begin
                        for (int k = 0; k < AXES; k++)
                            perm[k] = k;
                        for (int k = AXES - 1; k > 0; k--)
                        begin
                            j       = $urandom_range(0, k);
                            tmp     = perm[k];
                            perm[k] = perm[j];
                            perm[j] = tmp;
                        end
                        for (int k = 0; k < AXES; k++)
                            ord[3*k +: 3] = 3'(perm[k]);
                    end
                endcase
                write_reg(CFG_AXIS_ORDER, {43'd0, ord});
            end

            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_ELEM_BYTES, 64'($urandom_range(0, 3)));
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_ELEM_SIGNED, 64'($urandom_range(0, 1)));
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_SWAP_EN, 64'($urandom_range(0, 1)));

            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 7))
                    0: rnd = 64'(SCALE_ONE);
                    1: rnd = 64'd0;
                    2: rnd = 64'h8000_0000;
                    3: rnd = 64'h7FFF_FFFF;
                    4, 5: rnd = 64'($urandom);
                    default: rnd = 64'($urandom_range(0, 262143)) - 64'd131072;
                endcase
                write_reg(CFG_SCALE, {32'd0, rnd[31:0]});
            end

            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: rnd = 64'd0;
                    1: rnd = 64'h8000_0000;
                    2: rnd = 64'h7FFF_FFFF;
                    3: rnd = 64'($urandom);
                    default: rnd = 64'($urandom_range(0, 2000)) - 64'd1000;
                endcase
                write_reg(CFG_OFFSET, {32'd0, rnd[31:0]});
            end

            n_items = $urandom_range(70, 130);
            for (int n = 0; n < n_items; n++)
            begin
                // once, let the pipeline run dry in the middle of a stream
                if (phase == 2 && n == n_items / 2)
                    hold_until_drained();
                case ($urandom_range(0, 9))
                    0: raw = ONES;
                    1: raw = '0;
                    2: raw = 64'd1 << $urandom_range(0, 63);
                    3: raw = ~(64'd1 << $urandom_range(0, 63));
                    default: raw = {$urandom, $urandom};
                endcase
                send_element(raw, 1'b0, '0);
            end
        end

        // drain, then let the pipeline settle
        hold_until_drained();
        repeat (DRAIN_WAIT)
            @(posedge clk);

        $display("Sent %0d elements over %0d register writes and %0d random setups.",
                 items_sent, regs_written, PHASES);
        $display("Scored %0d results: %0d saturated, %0d volume ends.",
                 results_seen, sat_seen, ends_seen);
        if (errors == 0)
            $display("tb_permuted_volume_element_converter: done, clean");
        else
            $display("tb_permuted_volume_element_converter: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
